>>> src/biou_pkg.sv
`timescale 1ns / 1ps
package biou_pkg;
    localparam int CoordBits = 16;
    localparam int FracBits = 16;
    localparam int RatioBits = FracBits + 1;
    localparam int DistBits = 38;
    localparam int ExtBits = CoordBits + 1;
    localparam int VolBits = 3 * ExtBits;
    localparam int UnBits = VolBits + 1;
    localparam int RemBits = UnBits + 1;

    localparam logic [1:0] StatOverlap = 2'd0;
    localparam logic [1:0] StatApart = 2'd1;
    localparam logic [1:0] StatInvalid = 2'd2;

    typedef struct packed {
        logic signed [CoordBits-1:0] a_x_lo;
        logic signed [CoordBits-1:0] a_y_lo;
        logic signed [CoordBits-1:0] a_z_lo;
        logic signed [CoordBits-1:0] a_x_hi;
        logic signed [CoordBits-1:0] a_y_hi;
        logic signed [CoordBits-1:0] a_z_hi;
        logic signed [CoordBits-1:0] b_x_lo;
        logic signed [CoordBits-1:0] b_y_lo;
        logic signed [CoordBits-1:0] b_z_lo;
        logic signed [CoordBits-1:0] b_x_hi;
        logic signed [CoordBits-1:0] b_y_hi;
        logic signed [CoordBits-1:0] b_z_hi;
    } t_boxes;

    typedef struct packed {
        logic [RatioBits-1:0] overlap_ratio;
        logic [DistBits-1:0]  match_distance;
        logic [1:0]           status;
    } t_result;
endpackage

>>> src/biou_if.sv
`timescale 1ns / 1ps
interface biou_in_if;
    logic valid;
    logic ready;
    biou_pkg::t_boxes data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface biou_out_if;
    logic valid;
    logic ready;
    biou_pkg::t_result data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> src/box_iou_and_distance.sv
`timescale 1ns / 1ps
// Throughput: one transaction per cycle while the output is not stalled; stages are differences, products, volumes,
// union, then one quotient bit per stage of the restoring divider (17 stages).
// A stall at the output holds the whole pipeline in place.
// Reset (synchronous, active low) clears all valid bits; payload is not reset.
module box_iou_and_distance (
    input  logic i_clk,
    input  logic i_rst_n,
    biou_in_if.sink   i_box,
    biou_out_if.source o_res
);
    localparam int E = biou_pkg::ExtBits;
    localparam int V = biou_pkg::VolBits;
    localparam int U = biou_pkg::UnBits;
    localparam int R = biou_pkg::RemBits;
    localparam int Q = biou_pkg::RatioBits;
    localparam int D = biou_pkg::DistBits;

    logic w_adv;
    assign w_adv = !o_res.valid || o_res.ready;
    assign i_box.ready = w_adv;

    // Stage 1: per-axis differences and flags.
    logic signed [biou_pkg::CoordBits-1:0] w_alo [3], w_ahi [3], w_blo [3], w_bhi [3];
    assign w_alo[0] = i_box.data.a_x_lo; assign w_alo[1] = i_box.data.a_y_lo;
    assign w_alo[2] = i_box.data.a_z_lo; assign w_ahi[0] = i_box.data.a_x_hi;
    assign w_ahi[1] = i_box.data.a_y_hi; assign w_ahi[2] = i_box.data.a_z_hi;
    assign w_blo[0] = i_box.data.b_x_lo; assign w_blo[1] = i_box.data.b_y_lo;
    assign w_blo[2] = i_box.data.b_z_lo; assign w_bhi[0] = i_box.data.b_x_hi;
    assign w_bhi[1] = i_box.data.b_y_hi; assign w_bhi[2] = i_box.data.b_z_hi;

    logic r_v1;
    logic signed [E-1:0] r_dl [3], r_dh [3];
    logic signed [E:0] r_dc [3];
    logic [E-1:0] r_la [3], r_lb [3], r_li [3];
    logic r_inv1, r_apart1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (w_adv) begin
            r_v1 <= i_box.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        logic inv, apart;
        logic signed [E-1:0] lo, hi;
        if (w_adv) begin
            inv = 1'b0;
            apart = 1'b0;
            for (int k = 0; k < 3; k++) begin
                if (w_alo[k] > w_ahi[k] || w_blo[k] > w_bhi[k]) inv = 1'b1;
                if (w_ahi[k] <= w_blo[k] || w_bhi[k] <= w_alo[k]) apart = 1'b1;
                lo = (w_alo[k] > w_blo[k]) ? E'(w_alo[k]) : E'(w_blo[k]);
                hi = (w_ahi[k] < w_bhi[k]) ? E'(w_ahi[k]) : E'(w_bhi[k]);
                r_dl[k] <= E'(w_alo[k]) - E'(w_blo[k]);
                r_dh[k] <= E'(w_ahi[k]) - E'(w_bhi[k]);
                r_dc[k] <= ((E+1)'(w_alo[k]) + (E+1)'(w_ahi[k]))
                         - ((E+1)'(w_blo[k]) + (E+1)'(w_bhi[k]));
                r_la[k] <= E'(E'(w_ahi[k]) - E'(w_alo[k]));
                r_lb[k] <= E'(E'(w_bhi[k]) - E'(w_blo[k]));
                r_li[k] <= E'(hi - lo);
            end
            r_inv1 <= inv;
            r_apart1 <= apart;
        end
    end

    // Stage 2: squares for the distance and the first volume products.
    logic r_v2, r_inv2, r_apart2;
    logic [2*E+3:0] r_sq [3];
    logic [2*E-1:0] r_pa, r_pb, r_pi;
    logic [E-1:0] r_za, r_zb, r_zi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v2 <= 1'b0;
        else if (w_adv) r_v2 <= r_v1;
    end

    always_ff @(posedge i_clk) begin
        logic [2*E+3:0] sq_l, sq_h, sq_c;
        if (w_adv) begin
            for (int k = 0; k < 3; k++) begin
                // Operands are sign-extended first so the squares keep all their bits.
                sq_l = (2*E+4)'(unsigned'((2*E+2)'(r_dl[k]) * (2*E+2)'(r_dl[k])));
                sq_h = (2*E+4)'(unsigned'((2*E+2)'(r_dh[k]) * (2*E+2)'(r_dh[k])));
                sq_c = (2*E+4)'(unsigned'((2*E+2)'(r_dc[k]) * (2*E+2)'(r_dc[k])));
                r_sq[k] <= ((sq_l + sq_h) << 2) + sq_c;
            end
            r_pa <= (2*E)'(r_la[0]) * (2*E)'(r_la[1]);
            r_pb <= (2*E)'(r_lb[0]) * (2*E)'(r_lb[1]);
            r_pi <= (2*E)'(r_li[0]) * (2*E)'(r_li[1]);
            r_za <= r_la[2]; r_zb <= r_lb[2]; r_zi <= r_li[2];
            r_inv2 <= r_inv1;
            r_apart2 <= r_apart1;
        end
    end

    // Stage 3: volumes and distance sum.
    logic r_v3, r_inv3, r_apart3;
    logic [V-1:0] r_va, r_vb, r_vi;
    logic [D-1:0] r_dist3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v3 <= 1'b0;
        else if (w_adv) r_v3 <= r_v2;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_va <= V'(r_pa) * V'(r_za);
            r_vb <= V'(r_pb) * V'(r_zb);
            r_vi <= V'(r_pi) * V'(r_zi);
            r_dist3 <= D'(r_sq[0]) + D'(r_sq[1]) + D'(r_sq[2]);
            r_inv3 <= r_inv2;
            r_apart3 <= r_apart2;
        end
    end

    // Stage 4 (entry 0 of the divider arrays): union, with the intersection as remainder.
    // Divider: one quotient bit per stage, whole bit first.
    logic r_dv [Q+1];
    logic [R-1:0] r_rem [Q+1];
    logic [U-1:0] r_den [Q+1];
    logic [Q-1:0] r_quo [1:Q];
    logic [D-1:0] r_dd [Q+1];
    logic r_dinv [Q+1], r_dap [Q+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_dv[0] <= 1'b0;
        else if (w_adv) r_dv[0] <= r_v3;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_den[0] <= U'(r_va) + U'(r_vb) - U'(r_vi);
            r_rem[0] <= R'(r_vi);
            r_dd[0] <= r_dist3;
            r_dinv[0] <= r_inv3;
            r_dap[0] <= r_apart3;
        end
    end

    for (genvar s = 1; s <= Q; s++) begin : g_div
        logic [R-1:0] w_t;
        logic [Q-1:0] w_qin;
        if (s == 1) begin : g_whole
            assign w_t = r_rem[0];
            assign w_qin = '0;
        end else begin : g_frac
            assign w_t = {r_rem[s-1][R-2:0], 1'b0};
            assign w_qin = r_quo[s-1];
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_dv[s] <= 1'b0;
            else if (w_adv) r_dv[s] <= r_dv[s-1];
        end
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                if (w_t >= R'(r_den[s-1])) begin
                    r_rem[s] <= w_t - R'(r_den[s-1]);
                    r_quo[s] <= {w_qin[Q-2:0], 1'b1};
                end else begin
                    r_rem[s] <= w_t;
                    r_quo[s] <= {w_qin[Q-2:0], 1'b0};
                end
                r_den[s] <= r_den[s-1];
                r_dd[s] <= r_dd[s-1];
                r_dinv[s] <= r_dinv[s-1];
                r_dap[s] <= r_dap[s-1];
            end
        end
    end

    // Output register.
    logic r_ov;
    biou_pkg::t_result r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ov <= 1'b0;
        else if (w_adv) r_ov <= r_dv[Q];
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            if (r_dinv[Q]) begin
                r_out.overlap_ratio <= '0;
                r_out.match_distance <= '0;
                r_out.status <= biou_pkg::StatInvalid;
            end else if (r_dap[Q]) begin
                r_out.overlap_ratio <= '0;
                r_out.match_distance <= r_dd[Q];
                r_out.status <= biou_pkg::StatApart;
            end else begin
                r_out.overlap_ratio <= r_quo[Q];
                r_out.match_distance <= r_dd[Q];
                r_out.status <= biou_pkg::StatOverlap;
            end
        end
    end

    assign o_res.valid = r_ov;
    assign o_res.data = r_out;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.ready) |=> (o_res.valid && $stable(o_res.data)))
        else $error("result changed while stalled");
    a_ratio: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.data.overlap_ratio <= Q'(1 << biou_pkg::FracBits)))
        else $error("ratio above one");
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.data.status != biou_pkg::StatOverlap)
        |-> (o_res.data.overlap_ratio == '0))
        else $error("nonzero ratio without overlap");
endmodule

>>> verif/tb_box_iou_and_distance.sv
`timescale 1ns / 1ps
module tb_box_iou_and_distance;
    localparam int CB = biou_pkg::CoordBits;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    biou_in_if  box_ch ();
    biou_out_if res_ch ();

    box_iou_and_distance dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_box  (box_ch.sink),
        .o_res  (res_ch.source)
    );

    always #10 i_clk = ~i_clk;

    biou_pkg::t_boxes  pending_pairs[$];
    biou_pkg::t_result expected_scores[$];
    int      mismatch_count = 0;
    int      cycle_count = 0;
    bit      stimulus_done = 1'b0;
    bit      hold_until_drained = 1'b0;
    int      send_gap = 0;
    int      recv_gap = 0;

    localparam int CycleLimit = 400000;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Exact volume of a box; extents fit in 17 bits, so 51 bits hold the product.
    function automatic longint unsigned box_volume(longint lx, longint ly, longint lz,
                                                   longint hx, longint hy, longint hz);
        return longint'(hx - lx) * longint'(hy - ly) * longint'(hz - lz);
    endfunction

    function automatic biou_pkg::t_result score_pair(biou_pkg::t_boxes p);
        biou_pkg::t_result r;
        longint alo[3], ahi[3], blo[3], bhi[3], ilo[3], ihi[3];
        longint dl, dh, dc;
        longint unsigned dist_sum, vi, un, rem, quo;
        bit apart;
        alo = '{p.a_x_lo, p.a_y_lo, p.a_z_lo};
        ahi = '{p.a_x_hi, p.a_y_hi, p.a_z_hi};
        blo = '{p.b_x_lo, p.b_y_lo, p.b_z_lo};
        bhi = '{p.b_x_hi, p.b_y_hi, p.b_z_hi};
        r = '0;
        for (int k = 0; k < 3; k++) begin
            if (alo[k] > ahi[k] || blo[k] > bhi[k]) begin
                r.status = biou_pkg::StatInvalid;
                return r;
            end
        end
        dist_sum = 0;
        apart = 1'b0;
        for (int k = 0; k < 3; k++) begin
            dl = alo[k] - blo[k];
            dh = ahi[k] - bhi[k];
            dc = (alo[k] + ahi[k]) - (blo[k] + bhi[k]);
            dist_sum += 4 * (dl * dl + dh * dh) + dc * dc;
            if (ahi[k] <= blo[k] || bhi[k] <= alo[k]) apart = 1'b1;
            ilo[k] = (alo[k] > blo[k]) ? alo[k] : blo[k];
            ihi[k] = (ahi[k] < bhi[k]) ? ahi[k] : bhi[k];
        end
        r.match_distance = dist_sum[biou_pkg::DistBits-1:0];
        if (apart) begin
            r.status = biou_pkg::StatApart;
            return r;
        end
        vi = box_volume(ilo[0], ilo[1], ilo[2], ihi[0], ihi[1], ihi[2]);
        un = box_volume(alo[0], alo[1], alo[2], ahi[0], ahi[1], ahi[2])
           + box_volume(blo[0], blo[1], blo[2], bhi[0], bhi[1], bhi[2]) - vi;
        // Restoring division; the remainder stays below 2*un, well inside 64 bits.
        rem = vi;
        quo = 0;
        for (int k = 0; k <= biou_pkg::FracBits; k++) begin
            if (k > 0) rem = rem << 1;
            quo = quo << 1;
            if (rem >= un) begin
                rem -= un;
                quo |= 1;
            end
        end
        r.overlap_ratio = quo[biou_pkg::RatioBits-1:0];
        r.status = biou_pkg::StatOverlap;
        return r;
    endfunction

    function automatic logic signed [CB-1:0] rand_coord();
        case ($urandom_range(0, 3))
            0: return CB'($urandom);
            1: return CB'($urandom_range(0, 4095) - 2048);
            2: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            default: return CB'($urandom_range(0, 255) - 128);
        endcase
    endfunction

    // Builds a well-formed pair with random content; without spread the boxes lie nearby so overlap is common.
    function automatic biou_pkg::t_boxes rand_pair(bit spread);
        biou_pkg::t_boxes p;
        logic signed [CB-1:0] lo, hi, t;
        logic signed [CB-1:0] v[12];
        for (int k = 0; k < 3; k++) begin
            for (int b = 0; b < 2; b++) begin
                if (spread) begin
                    lo = rand_coord();
                    hi = rand_coord();
                end else begin
                    lo = CB'($urandom_range(0, 1023) - 512);
                    hi = CB'(lo + $urandom_range(0, 1023));
                end
                if (lo > hi) begin
                    t = lo; lo = hi; hi = t;
                end
                v[6 * b + k] = lo;
                v[6 * b + 3 + k] = hi;
            end
        end
        p = {v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], v[8], v[9], v[10], v[11]};
        return p;
    endfunction

    function automatic biou_pkg::t_boxes make_pair(int ax0, int ay0, int az0, int ax1,
                                                   int ay1, int az1, int bx0, int by0,
                                                   int bz0, int bx1, int by1, int bz1);
        biou_pkg::t_boxes p;
        p.a_x_lo = CB'(ax0); p.a_y_lo = CB'(ay0); p.a_z_lo = CB'(az0);
        p.a_x_hi = CB'(ax1); p.a_y_hi = CB'(ay1); p.a_z_hi = CB'(az1);
        p.b_x_lo = CB'(bx0); p.b_y_lo = CB'(by0); p.b_z_lo = CB'(bz0);
        p.b_x_hi = CB'(bx1); p.b_y_hi = CB'(by1); p.b_z_hi = CB'(bz1);
        return p;
    endfunction

    initial begin
        biou_pkg::t_boxes p;
        // Identical, nested, partial, touching, apart, invalid, extreme spans.
        pending_pairs.push_back(make_pair(0, 0, 0, 256, 256, 256, 0, 0, 0, 256, 256, 256));
        pending_pairs.push_back(make_pair(-32768, -32768, -32768, 32767, 32767, 32767,
                                          -32768, -32768, -32768, 32767, 32767, 32767));
        pending_pairs.push_back(make_pair(-32768, -32768, -32768, 32767, 32767, 32767,
                                          0, 0, 0, 1, 1, 1));
        pending_pairs.push_back(make_pair(-32768, -32768, -32768, 32767, 32767, 32767,
                                          32766, 32766, 32766, 32767, 32767, 32767));
        pending_pairs.push_back(make_pair(0, 0, 0, 100, 100, 100, 50, 50, 50, 150, 150, 150));
        pending_pairs.push_back(make_pair(0, 0, 0, 100, 100, 100, 100, 0, 0, 200, 100, 100));
        pending_pairs.push_back(make_pair(0, 0, 0, 100, 100, 100, 0, 0, 100, 100, 100, 200));
        pending_pairs.push_back(make_pair(-32768, -32768, -32768, -32768, -32768, -32768,
                                          32767, 32767, 32767, 32767, 32767, 32767));
        pending_pairs.push_back(make_pair(5, 5, 5, 5, 5, 5, 5, 5, 5, 5, 5, 5));
        pending_pairs.push_back(make_pair(-32768, 0, 0, 32767, 10, 10,
                                          32767, 0, 0, -32768, 10, 10));
        pending_pairs.push_back(make_pair(10, 0, 0, 9, 10, 10, 0, 0, 0, 10, 10, 10));
        pending_pairs.push_back(make_pair(0, 0, 0, 10, 10, 10, 0, 0, 11, 10, 10, 10));
        pending_pairs.push_back(make_pair(0, 0, 0, 1, 1, 1, 0, 0, 0, 32767, 32767, 32767));
        pending_pairs.push_back(make_pair(-1, -1, -1, 0, 0, 0, -1, -1, -1, 0, 0, 0));
        pending_pairs.push_back(make_pair(-300, -300, -300, 300, 300, 300,
                                          -32768, -32768, -32768, -299, 32767, 32767));
        for (int n = 0; n < 500; n++) begin
            case ($urandom_range(0, 9))
                0: p = biou_pkg::t_boxes'({$urandom, $urandom, $urandom, $urandom,
                                           $urandom, $urandom});
                1, 2: p = rand_pair(1'b1);
                default: p = rand_pair(1'b0);
            endcase
            pending_pairs.push_back(p);
            if (n == 250) pending_pairs.push_back('x);
        end
        stimulus_done = 1'b1;
    end

    // An all-x entry in the queue marks the point where the sender waits for drain.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            box_ch.valid <= 1'b0;
            box_ch.data  <= '0;
        end else if (!box_ch.valid || box_ch.ready) begin
            if (box_ch.valid) expected_scores.push_back(score_pair(box_ch.data));
            if (pending_pairs.size() > 0 && $isunknown(pending_pairs[0])) begin
                hold_until_drained <= 1'b1;
                void'(pending_pairs.pop_front());
                box_ch.valid <= 1'b0;
            end else if (hold_until_drained) begin
                box_ch.valid <= 1'b0;
                if (expected_scores.size() == 0 && !box_ch.valid)
                    hold_until_drained <= 1'b0;
            end else if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                box_ch.valid <= 1'b0;
            end else if (pending_pairs.size() > 0) begin
                box_ch.data  <= pending_pairs.pop_front();
                box_ch.valid <= 1'b1;
                send_gap <= pick_gap();
            end else begin
                box_ch.valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        biou_pkg::t_result want;
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                if (expected_scores.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("Unexpected result transaction: %p", res_ch.data);
                end else begin
                    want = expected_scores.pop_front();
                    if (res_ch.data !== want) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("Result mismatch: ratio %0d/%0d dist %0d/%0d %s %0d/%0d",
                                     want.overlap_ratio, res_ch.data.overlap_ratio,
                                     want.match_distance, res_ch.data.match_distance,
                                     "status", want.status, res_ch.data.status);
                    end
                end
            end
            if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= 1'b1;
                if ($urandom_range(0, 3) == 0) recv_gap <= pick_gap();
            end
        end
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (stimulus_done && pending_pairs.size() == 0 && !box_ch.valid
              && expected_scores.size() == 0);
        repeat (60) @(posedge i_clk);
        if (mismatch_count == 0 && expected_scores.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit) begin
            $display("Mismatches found");
            $finish;
        end
    end
endmodule
